>>> sv/tcmc_pkg.sv
// ----------------------------------------------------------------------------
// Three-C miss classifier package
// Shared constants and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tcmc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PID_W   = 2;
  localparam int unsigned CLS_W   = 2;

  // The seen map is stored as rows of this many flags.
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned ROW_SHIFT = 6;

  localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSTALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIT     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  localparam logic [CLS_W-1:0] CLS_COMPULSORY = 2'd0;
  localparam logic [CLS_W-1:0] CLS_CAPACITY   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_CONFLICT   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE       = 2'd3;

  localparam logic REG_LINE_SHIFT = 1'b0;
  localparam logic REG_CAPACITY   = 1'b1;

  localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST = 4'd6;
  localparam logic [CAP_W-1:0]   CAPACITY_RST   = 7'd64;

  typedef struct packed {
    logic init;     // reset sweep over both memories
    logic clr;      // sweep over one processor's state
    logic scan;     // search pass over the shadow entries
    logic upd;      // read-modify-write pass over the shadow entries
    logic latch;    // take the new item
    logic decide;   // settle eviction, insert slot and class
    logic seen_wr;  // mark the line seen
    logic finish;   // present the result
  } tcmc_cmd_t;

  typedef struct packed {
    logic last;      // the running sweep has reached its last step
    logic in_ok;     // incoming processor index is in range
    logic in_clear;  // incoming item is a clear
    logic probe;     // held item is a probe
    logic skip;      // nothing to update in the shadow
  } tcmc_stat_t;

endpackage

>>> sv/three_c_miss_classifier_unit.sv
// ----------------------------------------------------------------------------
// Three-C miss classifier unit
// Classifies data-cache misses per processor as compulsory, capacity or
// conflict from a seen map and a fully associative LRU shadow.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and each item gives one result on
// miss_class_o, marked by done_o for one cycle; the receiver cannot stall it.
// The shadow memory has one read and one write port, so every search walks
// all FA_LINES entries of the processor. A probe takes one search pass; an
// install or hit takes a search pass and a second pass that rewrites the LRU
// ages, skipped when a zero capacity drops the line from an empty shadow; a
// clear sweeps the processor's seen rows and shadow entries, and an item
// with an out-of-range processor goes straight to its result. The result
// appears in the cycle after the last busy cycle. After reset the unit
// sweeps both memories with busy high; configuration writes are taken at
// any time.
module three_c_miss_classifier_unit import tcmc_pkg::*; #(
  parameter int unsigned NUM_PROCS = 4,
  parameter int unsigned FA_LINES  = 64,
  parameter int unsigned SEEN_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [PID_W-1:0]  proc_id_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic              done_o,
  output logic [CLS_W-1:0]  miss_class_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  tcmc_cmd_t  cmd;
  tcmc_stat_t stat;

  tcmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tcmc_dp #(
    .NUM_PROCS (NUM_PROCS),
    .FA_LINES  (FA_LINES),
    .SEEN_BITS (SEEN_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .proc_id_i    (proc_id_i),
    .address_i    (address_i),
    .done_o       (done_o),
    .miss_class_o (miss_class_o)
  );

endmodule

>>> sv/tcmc_ctrl.sv
// ----------------------------------------------------------------------------
// Three-C miss classifier controller
// Sequences reset clearing, clears, searches and update passes.
// ----------------------------------------------------------------------------
module tcmc_ctrl import tcmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  tcmc_stat_t stat_i,
  output tcmc_cmd_t  cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_SEEN   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        if (stat_i.last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          if (!stat_i.in_ok) state_d = ST_DONE;
          else if (stat_i.in_clear) state_d = ST_CLEAR;
          else state_d = ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.last) state_d = ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.probe) state_d = ST_DONE;
        else if (stat_i.skip) state_d = ST_SEEN;
        else state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (stat_i.last) state_d = ST_SEEN;
      end
      ST_SEEN: begin
        cmd_o.seen_wr = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> sv/tcmc_dp.sv
// ----------------------------------------------------------------------------
// Three-C miss classifier datapath
// Seen-map and shadow memories, the sweep counter and the search state.
// ----------------------------------------------------------------------------
module tcmc_dp import tcmc_pkg::*; #(
  parameter int unsigned NUM_PROCS = 4,
  parameter int unsigned FA_LINES  = 64,
  parameter int unsigned SEEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcmc_cmd_t           cmd_i,
  output tcmc_stat_t          stat_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [PID_W-1:0]    proc_id_i,
  input  logic [ADDR_W-1:0]   address_i,
  output logic                done_o,
  output logic [CLS_W-1:0]    miss_class_o
);

  localparam int unsigned AW       = (FA_LINES > 1) ? $clog2(FA_LINES) : 1;
  localparam int unsigned CW       = $clog2(FA_LINES + 1);
  localparam int unsigned PW       = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned RB       = SEEN_BITS - ROW_SHIFT;
  localparam int unsigned RPP      = 1 << RB;
  localparam int unsigned SEEN_DEP = NUM_PROCS * RPP;
  localparam int unsigned SRW      = (SEEN_DEP > 1) ? $clog2(SEEN_DEP) : 1;
  localparam int unsigned SH_DEP   = NUM_PROCS * FA_LINES;
  localparam int unsigned SAW      = (SH_DEP > 1) ? $clog2(SH_DEP) : 1;
  localparam int unsigned INIT_N   = (SEEN_DEP > SH_DEP) ? SEEN_DEP : SH_DEP;
  localparam int unsigned CLR_N    = (RPP > FA_LINES) ? RPP : FA_LINES;
  localparam int unsigned CNT_MAX  = (INIT_N > FA_LINES) ? INIT_N : FA_LINES + 1;
  localparam int unsigned NW       = $clog2(CNT_MAX + 1);
  localparam int unsigned MW       = 1 + AW;

  // Configuration registers.
  logic [SHIFT_W-1:0] ls_q;
  logic [CAP_W-1:0]   cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q  <= LINE_SHIFT_RST;
      cap_q <= CAPACITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_SHIFT: ls_q  <= cfg_wdata_i[SHIFT_W-1:0];
        REG_CAPACITY:   cap_q <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Held item.
  logic [KIND_W-1:0] kind_q;
  logic [PW-1:0]     p_q;
  logic [ADDR_W-1:0] line_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      p_q    <= PW'(proc_id_i);
      line_q <= address_i >> ls_q;
    end
  end

  // Sweep counter; during scan and update passes the entry handled in a
  // cycle is the one read in the cycle before.
  logic [NW-1:0] cnt_q;
  logic [NW-1:0] lim;

  always_comb begin
    if (cmd_i.init) lim = NW'(INIT_N - 1);
    else if (cmd_i.clr) lim = NW'(CLR_N - 1);
    else lim = NW'(FA_LINES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.latch || cmd_i.decide || cmd_i.finish) begin
      cnt_q <= '0;
    end else if (cmd_i.init || cmd_i.clr || cmd_i.scan || cmd_i.upd) begin
      cnt_q <= cnt_q + NW'(1);
    end
  end

  logic [AW-1:0] j;
  logic          j_ok;
  assign j    = AW'(cnt_q - NW'(1));
  assign j_ok = (cnt_q != '0);

  // Seen map, one row of flags per word.
  logic [ROW_W-1:0] seen_mem [SEEN_DEP];
  logic [ROW_W-1:0] seen_rd_q;
  logic [SRW-1:0]   seen_ra;
  logic             seen_we;
  logic [SRW-1:0]   seen_wa;
  logic [ROW_W-1:0] seen_wd;

  assign seen_ra = SRW'(int'(p_q) * RPP + int'(line_q[SEEN_BITS-1:ROW_SHIFT]));

  always_comb begin
    seen_we = 1'b0;
    seen_wa = seen_ra;
    seen_wd = '0;
    if (cmd_i.init) begin
      seen_we = (int'(cnt_q) < SEEN_DEP);
      seen_wa = SRW'(cnt_q);
    end else if (cmd_i.clr) begin
      seen_we = (int'(cnt_q) < RPP);
      seen_wa = SRW'(int'(p_q) * RPP + int'(cnt_q));
    end else if (cmd_i.seen_wr) begin
      seen_we = 1'b1;
      seen_wd = seen_rd_q | (ROW_W'(1) << line_q[ROW_SHIFT-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_rd_q <= seen_mem[seen_ra];
  end

  // Shadow entries: tag memory and a meta memory holding valid and age.
  logic [ADDR_W-1:0] tag_mem  [SH_DEP];
  logic [MW-1:0]     meta_mem [SH_DEP];
  logic [ADDR_W-1:0] tag_rd_q;
  logic [MW-1:0]     meta_rd_q;
  logic [SAW-1:0]    sh_ra;
  logic              sh_we;
  logic [SAW-1:0]    sh_wa;
  logic [ADDR_W-1:0] tag_wd;
  logic [MW-1:0]     meta_wd;

  logic          e_valid;
  logic [AW-1:0] e_age;
  assign e_valid = meta_rd_q[MW-1];
  assign e_age   = meta_rd_q[AW-1:0];

  assign sh_ra = SAW'(int'(p_q) * FA_LINES + int'(cnt_q[AW-1:0]));

  // Search results.
  logic          hit_q;
  logic [AW-1:0] hit_idx_q, hit_age_q;
  logic [CW-1:0] count_q;
  logic          vfound_q, ffound_q;
  logic [AW-1:0] vic_q, old_q, free_q;
  logic          evict_q;
  logic [AW-1:0] slot_q;
  logic [CLS_W-1:0] pcls_q;

  logic [CW-1:0] cap_sat;
  logic          need_evict;
  logic          seen_bit;
  assign cap_sat    = (int'(cap_q) > FA_LINES) ? CW'(FA_LINES) : CW'(cap_q);
  assign need_evict = !hit_q && (({1'b0, count_q} + (CW+1)'(1)) > {1'b0, cap_sat});
  assign seen_bit   = seen_rd_q[line_q[ROW_SHIFT-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      hit_q    <= 1'b0;
      count_q  <= '0;
      vfound_q <= 1'b0;
      ffound_q <= 1'b0;
      hit_idx_q <= '0;
      hit_age_q <= '0;
      vic_q    <= '0;
      old_q    <= '0;
      free_q   <= '0;
    end else if (cmd_i.scan && j_ok) begin
      if (e_valid) begin
        count_q <= count_q + CW'(1);
        if (tag_rd_q == line_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= j;
          hit_age_q <= e_age;
        end
        if (!vfound_q || e_age >= old_q) begin
          vic_q    <= j;
          old_q    <= e_age;
          vfound_q <= 1'b1;
        end
      end else if (!ffound_q) begin
        free_q   <= j;
        ffound_q <= 1'b1;
      end
    end
    if (cmd_i.decide) begin
      evict_q <= need_evict;
      slot_q  <= (need_evict && !(ffound_q && free_q < vic_q)) ? vic_q : free_q;
      if (!seen_bit) pcls_q <= CLS_COMPULSORY;
      else if (hit_q) pcls_q <= CLS_CONFLICT;
      else pcls_q <= CLS_CAPACITY;
    end
  end

  // Shadow write port.
  logic          n_valid;
  always_comb begin
    sh_we   = 1'b0;
    sh_wa   = SAW'(int'(p_q) * FA_LINES + int'(j));
    tag_wd  = tag_rd_q;
    meta_wd = meta_rd_q;
    n_valid = e_valid;
    if (cmd_i.init) begin
      sh_we   = (int'(cnt_q) < SH_DEP);
      sh_wa   = SAW'(cnt_q);
      tag_wd  = '0;
      meta_wd = '0;
    end else if (cmd_i.clr) begin
      sh_we   = (int'(cnt_q) < FA_LINES);
      sh_wa   = SAW'(int'(p_q) * FA_LINES + int'(cnt_q));
      tag_wd  = '0;
      meta_wd = '0;
    end else if (cmd_i.upd && j_ok) begin
      sh_we = 1'b1;
      if (hit_q) begin
        if (j == hit_idx_q) meta_wd = {1'b1, AW'(0)};
        else if (e_valid && e_age < hit_age_q) meta_wd = {1'b1, e_age + AW'(1)};
      end else begin
        n_valid = e_valid && !(evict_q && j == vic_q);
        if (j == slot_q) begin
          tag_wd  = line_q;
          meta_wd = {1'b1, AW'(0)};
        end else if (n_valid) begin
          meta_wd = {1'b1, e_age + AW'(1)};
        end else begin
          meta_wd = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) begin
      tag_mem[sh_wa]  <= tag_wd;
      meta_mem[sh_wa] <= meta_wd;
    end
    tag_rd_q  <= tag_mem[sh_ra];
    meta_rd_q <= meta_mem[sh_ra];
  end

  // Result register; the held kind also reads as a probe for items whose
  // processor index was out of range, which skip the search, so the check is held.
  logic pid_ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) pid_ok_q <= (int'(proc_id_i) < NUM_PROCS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      miss_class_o <= (pid_ok_q && kind_q == KIND_PROBE) ? pcls_q : CLS_NONE;
    end
  end

  assign stat_o.last     = (cnt_q == lim);
  assign stat_o.in_ok    = (int'(proc_id_i) < NUM_PROCS);
  assign stat_o.in_clear = (kind_i == KIND_CLEAR);
  assign stat_o.probe    = (kind_q == KIND_PROBE);
  assign stat_o.skip     = need_evict && (count_q == '0);

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Three-C miss classifier testbench
// Drives probe, install, hit and clear items into the unit under several
// line shift and capacity settings, predicts each miss class with a shadow
// LRU model of its own, and compares every result as it appears.
// ----------------------------------------------------------------------------
module tb_top;
  import tcmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPROC    = 4;
  localparam int unsigned NLINES   = 64;
  localparam int unsigned SEEN_W   = 16;
  localparam int unsigned TAIL_CYC = 2 * NLINES + 20;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind_i;
  logic [PID_W-1:0]  proc_id_i;
  logic [ADDR_W-1:0] address_i;
  logic              done_o;
  logic [CLS_W-1:0]  miss_class_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  three_c_miss_classifier_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .proc_id_i   (proc_id_i),
    .address_i   (address_i),
    .done_o      (done_o),
    .miss_class_o(miss_class_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state.
  bit                  seen_flags [NPROC][1 << SEEN_W];
  logic [ADDR_W-1:0]   lru_tag    [NPROC][NLINES];
  bit                  lru_valid  [NPROC][NLINES];
  int unsigned         lru_rank   [NPROC][NLINES];
  logic [SHIFT_W-1:0]  cur_shift;
  logic [CAP_W-1:0]    cur_cap;

  logic [CLS_W-1:0] class_queue[$];
  int unsigned n_errors;
  int unsigned n_mismatch;
  int unsigned n_results;
  int unsigned n_items;
  int unsigned n_probes;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int find_line(int unsigned p, logic [ADDR_W-1:0] ln);
    for (int i = 0; i < NLINES; i++) begin
      if (lru_valid[p][i] && lru_tag[p][i] == ln) return i;
    end
    return -1;
  endfunction

  function automatic logic [CLS_W-1:0] predict_class(logic [KIND_W-1:0] k,
                                                     logic [PID_W-1:0] pid,
                                                     logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] ln;
    int unsigned p;
    int slot;
    int unsigned cap;
    int unsigned cnt;
    int unsigned age;
    int victim;
    int free_slot;
    ln = addr >> cur_shift;
    p = pid;
    if (p >= NPROC) return CLS_NONE;
    case (k)
      KIND_PROBE: begin
        if (!seen_flags[p][ln[SEEN_W-1:0]]) return CLS_COMPULSORY;
        if (find_line(p, ln) < 0) return CLS_CAPACITY;
        return CLS_CONFLICT;
      end
      KIND_INSTALL, KIND_HIT: begin
        seen_flags[p][ln[SEEN_W-1:0]] = 1'b1;
        slot = find_line(p, ln);
        if (slot >= 0) begin
          age = lru_rank[p][slot];
          for (int i = 0; i < NLINES; i++) begin
            if (lru_valid[p][i] && lru_rank[p][i] < age) lru_rank[p][i]++;
          end
          lru_rank[p][slot] = 0;
        end else begin
          cap = (cur_cap > NLINES) ? NLINES : cur_cap;
          cnt = 0;
          for (int i = 0; i < NLINES; i++) cnt += lru_valid[p][i];
          if (cnt + 1 > cap) begin
            // An empty shadow with no room drops the new line at once.
            if (cnt == 0) return CLS_NONE;
            victim = -1;
            for (int i = 0; i < NLINES; i++) begin
              if (lru_valid[p][i] && (victim < 0 || lru_rank[p][i] >= lru_rank[p][victim]))
                victim = i;
            end
            lru_valid[p][victim] = 1'b0;
          end
          free_slot = -1;
          for (int i = 0; i < NLINES; i++) begin
            if (lru_valid[p][i]) lru_rank[p][i]++;
            else if (free_slot < 0) free_slot = i;
          end
          lru_valid[p][free_slot] = 1'b1;
          lru_tag[p][free_slot]   = ln;
          lru_rank[p][free_slot]  = 0;
        end
        return CLS_NONE;
      end
      default: begin
        for (int i = 0; i < NLINES; i++) begin
          lru_valid[p][i] = 1'b0;
          lru_rank[p][i]  = 0;
        end
        for (int i = 0; i < (1 << SEEN_W); i++) seen_flags[p][i] = 1'b0;
        return CLS_NONE;
      end
    endcase
  endfunction

  // Sends one item in a burst-gap pattern; start stays high across a burst.
  int unsigned burst_left;

  task automatic send_item(logic [KIND_W-1:0] k, logic [PID_W-1:0] pid,
                           logic [ADDR_W-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start     <= 1'b1;
    kind_i    <= k;
    proc_id_i <= pid;
    address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    class_queue.push_back(predict_class(k, pid, addr));
    n_items++;
    if (k == KIND_PROBE) n_probes++;
  endtask

  task automatic go_idle();
    int unsigned guard;
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    guard = 0;
    while (class_queue.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_LINE_SHIFT) cur_shift = val[SHIFT_W-1:0];
    else cur_cap = val[CAP_W-1:0];
  endtask

  always @(posedge clk_i) begin
    logic [CLS_W-1:0] want;
    if (rst_ni && done_o) begin
      n_results++;
      if (class_queue.size() == 0) begin
        n_errors++;
        $display("ERROR: result %0d arrived with nothing expected", miss_class_o);
      end else begin
        want = class_queue.pop_front();
        if (want !== miss_class_o) begin
          n_errors++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: miss_class expected %0d got %0d", want, miss_class_o);
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr64();
    return {$urandom(), $urandom()};
  endfunction

  // Address of a small line number so reuse is frequent.
  function automatic logic [ADDR_W-1:0] line_to_addr(int unsigned ln);
    return (ADDR_W'(ln) << cur_shift) | ADDR_W'($urandom() & ((1 << cur_shift) - 1));
  endfunction

  task automatic test_directed();
    send_item(KIND_PROBE,   2'd0, 64'h0);
    send_item(KIND_INSTALL, 2'd0, 64'h0);
    send_item(KIND_PROBE,   2'd0, 64'h3F);
    send_item(KIND_HIT,     2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_PROBE,   2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_PROBE,   2'd3, 64'h0000_0000_003F_FFC0);
    send_item(KIND_INSTALL, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_INSTALL, 2'd2, 64'h5555_5555_5555_5555);
    send_item(KIND_PROBE,   2'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KIND_CLEAR,   2'd0, 64'h0);
    send_item(KIND_PROBE,   2'd0, 64'h0);
    send_item(KIND_CLEAR,   2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_PROBE,   2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    go_idle();
    // Zero capacity: a new line replaces the LRU line, or is dropped at once
    // when the shadow is empty.
    write_reg(REG_CAPACITY, 7'd0);
    write_reg(REG_LINE_SHIFT, 7'd15);
    send_item(KIND_INSTALL, 2'd2, 64'h8000);
    send_item(KIND_PROBE,   2'd2, 64'h8000);
    send_item(KIND_HIT,     2'd2, 64'h1_0000);
    send_item(KIND_PROBE,   2'd2, 64'h1_0000);
    go_idle();
    // Capacity above the shadow size saturates.
    write_reg(REG_CAPACITY, 7'd127);
    write_reg(REG_LINE_SHIFT, 7'd0);
    for (int i = 0; i < 4; i++) send_item(KIND_INSTALL, 2'd1, 64'(i));
    send_item(KIND_PROBE, 2'd1, 64'd2);
    go_idle();
  endtask

  task automatic test_shrink();
    // Fill a shadow, then lower the capacity: each insert evicts only one
    // line, so the shadow keeps its size.
    write_reg(REG_CAPACITY, 7'd8);
    write_reg(REG_LINE_SHIFT, 7'd12);
    send_item(KIND_CLEAR, 2'd0, 64'h0);
    for (int i = 0; i < 8; i++) send_item(KIND_INSTALL, 2'd0, line_to_addr(i));
    go_idle();
    write_reg(REG_CAPACITY, 7'd2);
    for (int i = 8; i < 12; i++) send_item(KIND_INSTALL, 2'd0, line_to_addr(i));
    for (int i = 0; i < 12; i++) send_item(KIND_PROBE, 2'd0, line_to_addr(i));
    go_idle();
  endtask

  task automatic run_random(int unsigned count, int unsigned span);
    int unsigned r;
    logic [KIND_W-1:0] k;
    logic [ADDR_W-1:0] a;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) k = KIND_PROBE;
      else if (r < 70) k = KIND_INSTALL;
      else if (r < 97) k = KIND_HIT;
      else k = KIND_CLEAR;
      if ($urandom_range(0, 9) == 0) a = rand_addr64();
      else a = line_to_addr($urandom_range(0, span));
      send_item(k, 2'($urandom_range(0, 3)), a);
    end
  endtask

  task automatic test_random();
    int unsigned shifts[5] = '{0, 6, 12, 3, 15};
    int unsigned caps[5]   = '{64, 1, 16, 0, 100};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LINE_SHIFT, CFG_W'(shifts[ph]));
      write_reg(REG_CAPACITY, CFG_W'(caps[ph]));
      run_random(290, (caps[ph] > 4) ? caps[ph] + caps[ph] / 2 : 8);
      go_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_PROBE;
    proc_id_i = '0;
    address_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_LINE_SHIFT;
    cfg_wdata_i = '0;
    cur_shift = LINE_SHIFT_RST;
    cur_cap = CAPACITY_RST;
    burst_left = 0;
    n_errors = 0;
    n_mismatch = 0;
    n_results = 0;
    n_items = 0;
    n_probes = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_shrink();
    test_random();
    $display("Covered %0d items (%0d probes), %0d results checked over several",
             n_items, n_probes, n_results);
    $display("line shift and capacity settings including the extremes.");
    if (n_errors == 0 && class_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results still expected", n_errors, class_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

  // About 1500 items plus reset sweep, clears and gaps.
  initial begin
    #20ms;
    $display("Timeout");
    $display("FAILURE");
    $finish;
  end

endmodule
